FILE: sv/ctsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctsc_pkg
// Shared types and constants for the capacitive touch sense controller.
// ----------------------------------------------------------------------------
package ctsc_pkg;

    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;
    localparam int PHASE_W   = 3;

    // measurement phases
    localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
    localparam logic [PHASE_W-1:0] PH_DISCHARGE = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CHARGE    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_BOOST     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DRAIN     = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_THRESHOLD = 2'd2;

    localparam logic [CFG_W-1:0] DISCHARGE_TICKS_RST = 20'd10000;
    localparam logic [CFG_W-1:0] TIMEOUT_LIMIT_RST   = 20'd620000;
    localparam logic [CFG_W-1:0] TOUCH_THRESHOLD_RST = 20'd1000;
    localparam logic [CFG_W-1:0] DELAY_MAX           = 20'hFFFFF;

    typedef struct packed {
        logic             send_level;
        logic             recv_output_enable;
        logic             recv_drive_level;
        logic             done_res;
        logic             timed_out;
        logic [CFG_W-1:0] charge_count;
        logic             touched;
    } result_t;

endpackage
`default_nettype wire

FILE: sv/ctsc_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctsc_step
// Next-state and per-tick result logic of the measurement sequencer.
// ----------------------------------------------------------------------------
module ctsc_step
    import ctsc_pkg::*;
#(
    parameter int COUNT_BITS = 20
)
(
    input  wire logic [PHASE_W-1:0]    phase,
    input  wire logic [CFG_W-1:0]      delay_count,
    input  wire logic [COUNT_BITS-1:0] total_count,
    input  wire logic [CFG_W-1:0]      discharge_ticks,
    input  wire logic [CFG_W-1:0]      timeout_limit,
    input  wire logic [CFG_W-1:0]      touch_threshold,
    input  wire logic                  start_req,
    input  wire logic                  recv_level,
    output logic      [PHASE_W-1:0]    phase_next,
    output logic      [CFG_W-1:0]      delay_next,
    output logic      [COUNT_BITS-1:0] total_next,
    output result_t                    res
);

    localparam int CW = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] bumped;
    logic [CFG_W-1:0]      delay_inc;
    logic [CW-1:0]         limit_ext;
    logic [CW-1:0]         thresh_ext;
    logic [CW-1:0]         total_ext;
    logic [CW-1:0]         bumped_ext;
    logic                  limit_now;
    logic                  limit_bumped;
    logic                  finish_to;
    logic                  finish_ok;

    assign limit_ext    = CW'(timeout_limit);
    assign thresh_ext   = CW'(touch_threshold);
    assign total_ext    = CW'(total_count);
    assign bumped       = total_count + COUNT_BITS'(1);
    assign bumped_ext   = CW'(bumped);
    assign limit_now    = (total_ext >= limit_ext) || (total_count == COUNT_MAX);
    assign limit_bumped = (bumped_ext >= limit_ext) || (bumped == COUNT_MAX);
    assign delay_inc    = (delay_count != DELAY_MAX) ? delay_count + CFG_W'(1) : delay_count;

    always_comb
    begin
        phase_next             = phase;
        delay_next             = delay_count;
        total_next             = total_count;
        finish_to              = 1'b0;
        finish_ok              = 1'b0;
        res                    = '0;
        case (phase)
            PH_DISCHARGE:
            begin
                res.recv_output_enable = 1'b1;
                delay_next             = delay_inc;
                if (delay_inc >= discharge_ticks)
                begin
                    phase_next = PH_CHARGE;
                    delay_next = '0;
                end
            end
            PH_CHARGE:
            begin
                res.send_level = 1'b1;
                if (limit_now)
                begin
                    finish_to = 1'b1;
                end
                else if (recv_level)
                begin
                    phase_next = PH_BOOST;
                end
                else
                begin
                    total_next = bumped;
                    finish_to  = limit_bumped;
                end
            end
            PH_BOOST:
            begin
                res.send_level         = 1'b1;
                res.recv_output_enable = 1'b1;
                res.recv_drive_level   = 1'b1;
                phase_next             = PH_DRAIN;
            end
            PH_DRAIN:
            begin
                if (limit_now)
                begin
                    finish_to = 1'b1;
                end
                else if (recv_level)
                begin
                    total_next = bumped;
                    finish_to  = limit_bumped;
                end
                else
                begin
                    finish_ok = 1'b1;
                end
            end
            default:
            begin
                // unused codes fall back to idle
                phase_next = PH_IDLE;
                if (start_req)
                begin
                    phase_next = PH_DISCHARGE;
                    delay_next = '0;
                    total_next = '0;
                end
            end
        endcase

        // a clean finish leaves the count untouched this tick
        if (finish_to)
        begin
            res.done_res  = 1'b1;
            res.timed_out = 1'b1;
            phase_next    = PH_IDLE;
        end
        else if (finish_ok)
        begin
            res.done_res     = 1'b1;
            res.charge_count = total_ext[CFG_W-1:0];
            res.touched      = (total_ext > thresh_ext);
            phase_next       = PH_IDLE;
        end
    end

endmodule
`default_nettype wire

FILE: sv/ctsc_skid.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctsc_skid
// Result register with a skid stage so the input side keeps moving while a
// result waits on the output.
// ----------------------------------------------------------------------------
module ctsc_skid
    import ctsc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         can_push,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    out_free;

    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = out_ready || !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (push)
            begin
                out_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

endmodule
`default_nettype wire

FILE: sv/capacitive_touch_sense_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// capacitive_touch_sense_controller
// RC charge-time touch sensor sequencer: discharge, charge, boost, drain.
// ----------------------------------------------------------------------------
// a tick's result is registered in the output register, or in the skid register while the output is held
// throughput: one tick per cycle while in_ready is high; the sequencer state updates in a single pass
// a two-entry result buffer keeps input ready while one result waits
// reset clears the phase to idle, both counters to zero and loads the
// register defaults; no clearing pass is needed
module capacitive_touch_sense_controller
    import ctsc_pkg::*;
#(
    parameter int COUNT_BITS = 20
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 start_req,
    input  wire logic                 recv_level,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      send_level,
    output logic                      recv_output_enable,
    output logic                      recv_drive_level,
    output logic                      done_res,
    output logic                      timed_out,
    output logic      [CFG_W-1:0]     charge_count,
    output logic                      touched
);

    logic [CFG_W-1:0]      discharge_ticks_reg;
    logic [CFG_W-1:0]      timeout_limit_reg;
    logic [CFG_W-1:0]      touch_threshold_reg;
    logic [PHASE_W-1:0]    phase_reg;
    logic [PHASE_W-1:0]    phase_next;
    logic [CFG_W-1:0]      delay_reg;
    logic [CFG_W-1:0]      delay_next;
    logic [COUNT_BITS-1:0] total_reg;
    logic [COUNT_BITS-1:0] total_next;
    logic                  in_xfer;
    result_t               step_res;
    result_t               out_res;

    assign in_xfer = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discharge_ticks_reg <= DISCHARGE_TICKS_RST;
            timeout_limit_reg   <= TIMEOUT_LIMIT_RST;
            touch_threshold_reg <= TOUCH_THRESHOLD_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_DISCHARGE_TICKS: discharge_ticks_reg <= cfg_wdata;
                CFG_TIMEOUT_LIMIT:   timeout_limit_reg   <= cfg_wdata;
                CFG_TOUCH_THRESHOLD: touch_threshold_reg <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            delay_reg <= '0;
            total_reg <= '0;
        end
        else if (in_xfer)
        begin
            phase_reg <= phase_next;
            delay_reg <= delay_next;
            total_reg <= total_next;
        end
    end

    ctsc_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .phase           (phase_reg),
        .delay_count     (delay_reg),
        .total_count     (total_reg),
        .discharge_ticks (discharge_ticks_reg),
        .timeout_limit   (timeout_limit_reg),
        .touch_threshold (touch_threshold_reg),
        .start_req       (start_req),
        .recv_level      (recv_level),
        .phase_next      (phase_next),
        .delay_next      (delay_next),
        .total_next      (total_next),
        .res             (step_res)
    );

    ctsc_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_xfer),
        .push_data (step_res),
        .can_push  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_res)
    );

    assign send_level         = out_res.send_level;
    assign recv_output_enable = out_res.recv_output_enable;
    assign recv_drive_level   = out_res.recv_drive_level;
    assign done_res           = out_res.done_res;
    assign timed_out          = out_res.timed_out;
    assign charge_count       = out_res.charge_count;
    assign touched            = out_res.touched;

    a_start_discharge: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && phase_reg == PH_IDLE && start_req) |=> (phase_reg == PH_DISCHARGE))
        else $error("idle start did not enter discharge");

    a_boost_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && phase_reg == PH_BOOST) |=> (phase_reg == PH_DRAIN))
        else $error("boost lasted longer than one tick");

    a_touch_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && touched) |-> (done_res && !timed_out))
        else $error("touch reported without a clean finish");

    a_timeout_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && timed_out) |-> (done_res && charge_count == '0))
        else $error("timeout result carries a count");

endmodule
`default_nettype wire
